[src/cmtp_pkg.sv]
// Shared types, constants and tables of the complex mean to polar block.
`timescale 1ns / 1ps

package cmtp_pkg;

    localparam int ANG_FRAC = 24;   // fraction bits of internal angles
    localparam int ITERS    = 28;   // CORDIC iterations
    localparam int GUARD    = 8;    // guard bits of the rotation datapath
    localparam int RW       = 42;   // rotation x/y width
    localparam int PW       = 34;   // rectangular sample after rotation
    localparam int ZW       = 36;   // angle accumulator width
    localparam int VW       = 36;   // vectoring x/y width
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 9;

    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    localparam logic signed [ZW-1:0] Q90  = ZW'(90)  <<< ANG_FRAC;
    localparam logic signed [ZW-1:0] Q180 = ZW'(180) <<< ANG_FRAC;
    localparam logic signed [ZW-1:0] Q360 = ZW'(360) <<< ANG_FRAC;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RADIUS = 2'd1,
        ST_ANGLE  = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [SUM_W-1:0]   sum_r;
        logic signed [SUM_W-1:0]   sum_i;
        logic [CNT_W-1:0]          cnt;
    } job_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = ZW'(754974720);
            5'd1:    v = ZW'(445687602);
            5'd2:    v = ZW'(235489088);
            5'd3:    v = ZW'(119537938);
            5'd4:    v = ZW'(60000934);
            5'd5:    v = ZW'(30029717);
            5'd6:    v = ZW'(15018523);
            5'd7:    v = ZW'(7509720);
            5'd8:    v = ZW'(3754917);
            5'd9:    v = ZW'(1877466);
            5'd10:   v = ZW'(938734);
            5'd11:   v = ZW'(469367);
            5'd12:   v = ZW'(234684);
            5'd13:   v = ZW'(117342);
            5'd14:   v = ZW'(58671);
            5'd15:   v = ZW'(29335);
            5'd16:   v = ZW'(14668);
            5'd17:   v = ZW'(7334);
            5'd18:   v = ZW'(3667);
            5'd19:   v = ZW'(1833);
            5'd20:   v = ZW'(917);
            5'd21:   v = ZW'(458);
            5'd22:   v = ZW'(229);
            5'd23:   v = ZW'(115);
            5'd24:   v = ZW'(57);
            5'd25:   v = ZW'(29);
            5'd26:   v = ZW'(14);
            5'd27:   v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/cmtp_front.sv]
// Front end: takes samples, checks polar ranges, rotates polar samples, accumulates sums.
`timescale 1ns / 1ps

module cmtp_front #(
    parameter int MAX_COUNT = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,
    input  logic [8:0]            sample_count,
    input  logic                  input_form,
    output logic                  job_valid,
    input  logic                  job_ready,
    output cmtp_pkg::job_t        job
);

    localparam int RW = cmtp_pkg::RW;
    localparam int ZW = cmtp_pkg::ZW;
    localparam int PW = cmtp_pkg::PW;
    localparam int SW = cmtp_pkg::SUM_W;
    localparam int SH = cmtp_pkg::ANG_FRAC - FRAC_BITS;
    localparam logic [63:0] MODC = 64'(360) << FRAC_BITS;
    localparam int MOD_STEPS = $clog2(((64'd1 << 31) / MODC) + 1);
    localparam int MOD_N = (MOD_STEPS < 1) ? 1 : MOD_STEPS;
    localparam logic signed [31:0] LIM90 = 32'(90) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] HALF_G = RW'(1) <<< (cmtp_pkg::GUARD - 1);

    typedef enum logic [2:0] {F_IDLE, F_MOD, F_MUL, F_ROT, F_ACC} fstate_t;

    fstate_t                state_reg, state_next;
    logic signed [31:0]     a_reg, a_next;
    logic [31:0]            rem_reg, rem_next;
    logic [4:0]             step_reg, step_next;
    logic                   polar_reg, polar_next;
    cmtp_pkg::status_t      err_reg, err_next;
    logic signed [RW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]   z_reg, z_next;
    logic [4:0]             it_reg, it_next;
    logic signed [SW-1:0]   sum_r_reg, sum_r_next, sum_i_reg, sum_i_next;
    logic [8:0]             seen_reg, seen_next;

    logic signed [31:0]     in_a, in_b;
    logic signed [63:0]     prod;
    logic signed [RW-1:0]   x0, dx, dy, xr, yr;
    logic signed [ZW-1:0]   z0;
    logic signed [PW-1:0]   px, py;
    logic signed [SW-1:0]   acc_r, acc_i;
    logic [8:0]             cnt, seen_inc;
    logic                   need_push;

    assign in_a = $signed(s_tdata[31:0]);
    assign in_b = $signed(s_tdata[63:32]);
    assign s_tready = (state_reg == F_IDLE);

    always_comb begin
        if (sample_count == 9'd0) begin
            cnt = 9'd1;
        end else if ({8'b0, sample_count} > 17'(MAX_COUNT)) begin
            cnt = 9'(MAX_COUNT);
        end else begin
            cnt = sample_count;
        end
    end

    // radius scaled by the inverse CORDIC gain, keeping guard bits
    assign prod = 64'(a_reg) * $signed({34'b0, cmtp_pkg::KINV_Q30});
    assign x0   = RW'((prod + 64'sd2097152) >>> (30 - cmtp_pkg::GUARD));
    assign dx   = y_reg >>> it_reg;
    assign dy   = x_reg >>> it_reg;
    assign xr   = (x_reg + HALF_G) >>> cmtp_pkg::GUARD;
    assign yr   = (y_reg + HALF_G) >>> cmtp_pkg::GUARD;
    assign px   = polar_reg ? xr[PW-1:0] : PW'(a_reg);
    assign py   = polar_reg ? yr[PW-1:0] : PW'($signed(rem_reg));
    assign acc_r = sum_r_reg + SW'(px);
    assign acc_i = sum_i_reg + SW'(py);
    assign seen_inc = seen_reg + 9'd1;
    assign need_push = (state_reg == F_ACC) &&
                       ((err_reg != cmtp_pkg::ST_OK) || (seen_inc >= cnt));
    assign job_valid = need_push;

    always_comb begin
        job.status = err_reg;
        job.sum_r  = (err_reg == cmtp_pkg::ST_OK) ? acc_r : '0;
        job.sum_i  = (err_reg == cmtp_pkg::ST_OK) ? acc_i : '0;
        job.cnt    = cnt;
    end

    always_comb begin
        z0 = ZW'(rem_reg) <<< SH;
        if (z0 >= cmtp_pkg::Q180) begin
            z0 = z0 - cmtp_pkg::Q360;
        end
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        polar_next = polar_reg;
        err_next   = err_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        sum_r_next = sum_r_reg;
        sum_i_next = sum_i_reg;
        seen_next  = seen_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    a_next     = in_a;
                    rem_next   = s_tdata[63:32];
                    polar_next = input_form;
                    step_next  = 5'(MOD_N - 1);
                    err_next   = cmtp_pkg::ST_OK;
                    state_next = F_ACC;
                    if (input_form) begin
                        if (in_a <= 0 || in_a >= LIM90) begin
                            err_next = cmtp_pkg::ST_RADIUS;
                        end else if (in_b <= 0) begin
                            err_next = cmtp_pkg::ST_ANGLE;
                        end else begin
                            state_next = F_MOD;
                        end
                    end
                end
            end
            F_MOD: begin
                // angle mod 360 degrees by shifted subtraction
                if ({32'b0, rem_reg} >= (MODC << step_reg)) begin
                    rem_next = rem_reg - 32'(MODC << step_reg);
                end
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0) begin
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                it_next = '0;
                if (z0 > cmtp_pkg::Q90) begin
                    x_next = '0;
                    y_next = x0;
                    z_next = z0 - cmtp_pkg::Q90;
                end else if (z0 < -cmtp_pkg::Q90) begin
                    x_next = '0;
                    y_next = -x0;
                    z_next = z0 + cmtp_pkg::Q90;
                end else begin
                    x_next = x0;
                    y_next = '0;
                    z_next = z0;
                end
                state_next = F_ROT;
            end
            F_ROT: begin
                if (z_reg >= 0) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - cmtp_pkg::atan_deg(it_reg);
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + cmtp_pkg::atan_deg(it_reg);
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'(cmtp_pkg::ITERS - 1)) begin
                    state_next = F_ACC;
                end
            end
            F_ACC: begin
                if (!need_push || job_ready) begin
                    state_next = F_IDLE;
                    if (need_push) begin
                        sum_r_next = '0;
                        sum_i_next = '0;
                        seen_next  = '0;
                    end else begin
                        sum_r_next = acc_r;
                        sum_i_next = acc_i;
                        seen_next  = seen_inc;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            sum_r_reg <= '0;
            sum_i_reg <= '0;
            seen_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sum_r_reg <= sum_r_next;
            sum_i_reg <= sum_i_next;
            seen_reg  <= seen_next;
        end
        a_reg     <= a_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        polar_reg <= polar_next;
        err_reg   <= err_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        it_reg    <= it_next;
    end

endmodule

[src/cmtp_fifo.sv]
// Two-entry queue of mean and error jobs between front and back end.
`timescale 1ns / 1ps

module cmtp_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  cmtp_pkg::job_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cmtp_pkg::job_t  pop_data
);

    cmtp_pkg::job_t mem_reg [2];
    logic           wr_reg, rd_reg;
    logic [1:0]     count_reg;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

[src/cmtp_back.sv]
// Back end: divides the sums, takes magnitude by integer sqrt and angle by CORDIC vectoring.
`timescale 1ns / 1ps

module cmtp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  cmtp_pkg::job_t  job,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,
    output logic [7:0]      m_tuser
);

    localparam int VW = cmtp_pkg::VW;
    localparam int ZW = cmtp_pkg::ZW;
    localparam int SW = cmtp_pkg::SUM_W;
    localparam int SH = cmtp_pkg::ANG_FRAC - FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF_Z = (SH == 0) ? '0 : (ZW'(1) <<< (SH - 1));
    localparam logic signed [ZW-1:0] LIM180 = ZW'(180) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] NORM_LIM = VW'(1) <<< 30;

    typedef enum logic [3:0] {
        B_IDLE, B_DIV, B_SAT, B_SQA, B_SQB, B_SQRT, B_NORM, B_VROT, B_OUT
    } bstate_t;

    bstate_t               state_reg, state_next;
    cmtp_pkg::status_t     st_reg, st_next;
    logic                  negr_reg, negr_next, negi_reg, negi_next;
    logic [SW-1:0]         qr_reg, qr_next, qi_reg, qi_next;
    logic [9:0]            remr_reg, remr_next, remi_reg, remi_next;
    logic [8:0]            cnt_reg, cnt_next;
    logic [5:0]            it_reg, it_next;
    logic signed [31:0]    mx_reg, mx_next, my_reg, my_next;
    logic [63:0]           sq_reg, sq_next, res_reg, res_next, bit_reg, bit_next;
    logic signed [VW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic                  zero_reg, zero_next;
    logic                  ov_reg, ov_next;
    logic [31:0]           mag_reg, mag_next;
    logic [24:0]           ang_reg, ang_next;
    cmtp_pkg::status_t     ost_reg, ost_next;

    logic [9:0]            shr, shi;
    logic [31:0]           ax, ay;
    logic [63:0]           sqr, trial;
    logic signed [VW-1:0]  vax, vay, vm, dx, dy;
    logic signed [ZW-1:0]  zr;

    assign job_ready = (state_reg == B_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {7'b0, ang_reg, mag_reg};
    assign m_tuser   = {6'b0, ost_reg};

    assign shr   = {remr_reg[8:0], qr_reg[SW-1]};
    assign shi   = {remi_reg[8:0], qi_reg[SW-1]};
    assign ax    = mx_reg[31] ? 32'(-mx_reg) : 32'(mx_reg);
    assign ay    = my_reg[31] ? 32'(-my_reg) : 32'(my_reg);
    assign sqr   = (it_reg[0] ? 64'(ay) * 64'(ay) : 64'(ax) * 64'(ax));
    assign trial = res_reg + bit_reg;
    assign vax   = x_reg[VW-1] ? -x_reg : x_reg;
    assign vay   = y_reg[VW-1] ? -y_reg : y_reg;
    assign vm    = (vay > vax) ? vay : vax;
    assign dx    = y_reg >>> it_reg[4:0];
    assign dy    = x_reg >>> it_reg[4:0];
    assign zr    = (z_reg + HALF_Z) >>> SH;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        negr_next  = negr_reg;
        negi_next  = negi_reg;
        qr_next    = qr_reg;
        qi_next    = qi_reg;
        remr_next  = remr_reg;
        remi_next  = remi_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        sq_next    = sq_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        ov_next    = ov_reg && !m_tready;
        mag_next   = mag_reg;
        ang_next   = ang_reg;
        ost_next   = ost_reg;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    st_next   = job.status;
                    negr_next = job.sum_r[SW-1];
                    negi_next = job.sum_i[SW-1];
                    qr_next   = job.sum_r[SW-1] ? SW'(-job.sum_r) : SW'(job.sum_r);
                    qi_next   = job.sum_i[SW-1] ? SW'(-job.sum_i) : SW'(job.sum_i);
                    remr_next = '0;
                    remi_next = '0;
                    cnt_next  = job.cnt;
                    it_next   = '0;
                    state_next = (job.status == cmtp_pkg::ST_OK) ? B_DIV : B_OUT;
                end
            end
            B_DIV: begin
                // restoring division, one quotient bit per cycle for both parts
                if (shr >= {1'b0, cnt_reg}) begin
                    remr_next = shr - {1'b0, cnt_reg};
                    qr_next   = {qr_reg[SW-2:0], 1'b1};
                end else begin
                    remr_next = shr;
                    qr_next   = {qr_reg[SW-2:0], 1'b0};
                end
                if (shi >= {1'b0, cnt_reg}) begin
                    remi_next = shi - {1'b0, cnt_reg};
                    qi_next   = {qi_reg[SW-2:0], 1'b1};
                end else begin
                    remi_next = shi;
                    qi_next   = {qi_reg[SW-2:0], 1'b0};
                end
                it_next = it_reg + 6'd1;
                if (it_reg == 6'(SW - 1)) begin
                    state_next = B_SAT;
                end
            end
            B_SAT: begin
                if (negr_reg) begin
                    mx_next = (qr_reg > 40'h0080000000) ? 32'sh80000000 : 32'(-qr_reg);
                end else begin
                    mx_next = (qr_reg > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : 32'(qr_reg);
                end
                if (negi_reg) begin
                    my_next = (qi_reg > 40'h0080000000) ? 32'sh80000000 : 32'(-qi_reg);
                end else begin
                    my_next = (qi_reg > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : 32'(qi_reg);
                end
                it_next    = '0;
                state_next = B_SQA;
            end
            B_SQA: begin
                sq_next    = sqr;
                it_next    = 6'd1;
                state_next = B_SQB;
            end
            B_SQB: begin
                sq_next    = sq_reg + sqr;
                res_next   = '0;
                bit_next   = 64'd1 << 62;
                it_next    = '0;
                state_next = B_SQRT;
            end
            B_SQRT: begin
                if (sq_reg >= trial) begin
                    sq_next  = sq_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                it_next  = it_reg + 6'd1;
                if (it_reg == 6'd31) begin
                    x_next     = VW'(mx_reg);
                    y_next     = VW'(my_reg);
                    zero_next  = (mx_reg == 0) && (my_reg == 0);
                    state_next = B_NORM;
                end
            end
            B_NORM: begin
                it_next = '0;
                if (zero_reg) begin
                    z_next     = '0;
                    state_next = B_OUT;
                end else if (vm < NORM_LIM) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    state_next = B_VROT;
                    z_next     = '0;
                    if (x_reg[VW-1]) begin
                        if (!y_reg[VW-1]) begin
                            x_next = y_reg;
                            y_next = -x_reg;
                            z_next = cmtp_pkg::Q90;
                        end else begin
                            x_next = -y_reg;
                            y_next = x_reg;
                            z_next = -cmtp_pkg::Q90;
                        end
                    end
                end
            end
            B_VROT: begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + cmtp_pkg::atan_deg(it_reg[4:0]);
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - cmtp_pkg::atan_deg(it_reg[4:0]);
                end
                it_next = it_reg + 6'd1;
                if (it_reg == 6'(cmtp_pkg::ITERS - 1)) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next  = 1'b1;
                    ost_next = st_reg;
                    if (st_reg != cmtp_pkg::ST_OK) begin
                        mag_next = '0;
                        ang_next = '0;
                    end else begin
                        mag_next = res_reg[31:0];
                        if (zero_reg) begin
                            ang_next = '0;
                        end else if (zr > LIM180) begin
                            ang_next = LIM180[24:0];
                        end else if (zr < -LIM180) begin
                            ang_next = 25'(-LIM180);
                        end else begin
                            ang_next = zr[24:0];
                        end
                    end
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        st_reg   <= st_next;
        negr_reg <= negr_next;
        negi_reg <= negi_next;
        qr_reg   <= qr_next;
        qi_reg   <= qi_next;
        remr_reg <= remr_next;
        remi_reg <= remi_next;
        cnt_reg  <= cnt_next;
        it_reg   <= it_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        mag_reg  <= mag_next;
        ang_reg  <= ang_next;
        ost_reg  <= ost_next;
    end

endmodule

[src/complex_mean_to_polar.sv]
// Top level of the complex mean to polar block: config registers, front end, queue, back end.
`timescale 1ns / 1ps

// Averages sample_count complex samples (rectangular, or polar with degree
// angles) and returns the mean as magnitude (unsigned Q16.16, saturating) and
// atan2 angle in degrees (signed Q8.16); inputs are signed Q15.16 by default.
// One request on s_ carries one sample; every sample_count requests, or on
// any polar range error, one result request leaves on m_. In the front end a
// rectangular sample is taken and accumulated; a polar sample passes accept,
// 7 angle-modulo steps, 1 radius scaling, 28-step CORDIC rotation and
// accumulate. A mean passes in the back end a 40-step divider, saturate,
// squaring of both parts, 32-step square root, normalize shifts depending
// on the size of the mean, 28-step vectoring and output; a two-entry job
// queue lets the front keep taking samples meanwhile. Error results go
// straight to the output in the back end. No clearing pass after reset.
// Write configuration only while the block is idle.

module complex_mean_to_polar #(
    parameter int MAX_COUNT = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,     // 0 sample_count, 1 input_form
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // value_a [31:0], value_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // magnitude [31:0], angle_deg [56:32]
    output logic [7:0]  m_tuser       // status [1:0]
);

    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_FORM  = 1'b1;

    logic [8:0]     sample_count_reg;
    logic           input_form_reg;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    cmtp_pkg::job_t push_data, pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= 9'd3;
            input_form_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_COUNT: sample_count_reg <= cfg_wdata;
                CFG_FORM:  input_form_reg   <= cfg_wdata[0];
                default:   sample_count_reg <= sample_count_reg;
            endcase
        end
    end

    // samples in, polar rotation, running sums
    cmtp_front #(
        .MAX_COUNT (MAX_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .sample_count (sample_count_reg),
        .input_form   (input_form_reg),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job          (push_data)
    );

    cmtp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // mean, magnitude and angle, with the output register
    cmtp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[bench/tb_cmtp_regs_pkg.sv]
// Register index names shared by the bench top and the checker.
`timescale 1ns / 1ps

package tb_cmtp_regs_pkg;
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_INPUT_FORM   = 1'b1;
    localparam logic FORM_RECT        = 1'b0;
    localparam logic FORM_POLAR       = 1'b1;
endpackage

[bench/cmtp_checker.sv]
// Checker: snoops config, sample and result channels, predicts and compares results.
`timescale 1ns / 1ps

module cmtp_checker
    import cmtp_pkg::*;
    import tb_cmtp_regs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [7:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] magnitude;
        logic [24:0] angle_deg;
        status_t     status;
    } mean_result_t;

    localparam longint FRAC  = 16;
    localparam longint AFRAC = 24;
    localparam longint KINV  = 652032874;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_TBL [28] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [8:0]              count_reg;
    logic                    form_reg;
    logic signed [39:0]      acc_real;
    logic signed [39:0]      acc_imag;
    logic [8:0]              seen;
    mean_result_t            mean_q[$];

    function automatic longint round_shift(input longint v, input int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void rotate_polar(input longint r, input longint a,
                                         output longint px, output longint py);
        longint z, q, x, y, dx, dy;
        z = (a % (longint'(360) <<< FRAC)) <<< (AFRAC - FRAC);
        q = longint'(90) <<< AFRAC;
        x = round_shift(r * KINV, 22);
        y = 0;
        if (z >= 2 * q) z -= 4 * q;
        if (z > q) begin
            y = x; x = 0; z -= q;
        end else if (z < -q) begin
            y = -x; x = 0; z += q;
        end
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        px = round_shift(x, 8);
        py = round_shift(y, 8);
    endfunction

    function automatic longint atan2_deg(input longint x_in, input longint y_in);
        longint x, y, z, m, t, q, lim, dx, dy;
        x = x_in; y = y_in; z = 0;
        q = longint'(90) <<< AFRAC;
        if (x == 0 && y == 0) return 0;
        m = x < 0 ? -x : x;
        t = y < 0 ? -y : y;
        if (t > m) m = t;
        while (m < (longint'(1) <<< 30)) begin
            x *= 2; y *= 2; m *= 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = q;
            end else begin
                t = x; x = -y; y = t; z = -q;
            end
        end
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        z = round_shift(z, AFRAC - FRAC);
        lim = longint'(180) <<< FRAC;
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, res, b;
        v = v_in; res = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Folds one sample into the running sums, queues a result when one is due.
    function automatic void absorb_sample(input logic [31:0] a_bits,
                                          input logic [31:0] b_bits);
        longint a, b, x, y, n, mx, my;
        longint unsigned ax, ay, mag;
        status_t st;
        mean_result_t res;
        a = longint'(signed'(a_bits));
        b = longint'(signed'(b_bits));
        x = a; y = b; st = ST_OK;
        if (form_reg == FORM_POLAR) begin
            if (a <= 0 || a >= (longint'(90) <<< FRAC)) st = ST_RADIUS;
            else if (b <= 0) st = ST_ANGLE;
            else rotate_polar(a, b, x, y);
        end
        if (st != ST_OK) begin
            acc_real = '0; acc_imag = '0; seen = '0;
            res.magnitude = '0; res.angle_deg = '0; res.status = st;
            mean_q.push_back(res);
            return;
        end
        acc_real = acc_real + 40'(x);
        acc_imag = acc_imag + 40'(y);
        n = longint'(count_reg);
        if (n < 1) n = 1;
        if (n > 256) n = 256;
        seen = seen + 9'd1;
        if (longint'(seen) < n) return;
        mx = clamp32(longint'(acc_real) / n);
        my = clamp32(longint'(acc_imag) / n);
        acc_real = '0; acc_imag = '0; seen = '0;
        ax = longint'(mx < 0 ? -mx : mx);
        ay = longint'(my < 0 ? -my : my);
        mag = int_sqrt(ax * ax + ay * ay);
        if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
        res.magnitude = mag[31:0];
        res.angle_deg = 25'(atan2_deg(mx, my));
        res.status = ST_OK;
        mean_q.push_back(res);
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        mean_result_t want;
        if (!aresetn) begin
            count_reg = 9'd3; form_reg = FORM_RECT;
            acc_real = '0; acc_imag = '0; seen = '0;
            mean_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_SAMPLE_COUNT) count_reg = cfg_wdata;
                else form_reg = cfg_wdata[0];
            end
            if (s_tvalid && s_tready) absorb_sample(s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected result: magnitude %h angle_deg %h status %0d",
                           m_tdata[31:0], m_tdata[56:32], m_tuser[1:0]);
                    fail_count++;
                end else begin
                    want = mean_q.pop_front();
                    if (m_tdata[31:0] !== want.magnitude) begin
                        $error("magnitude: expected %h actual %h",
                               want.magnitude, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[56:32] !== want.angle_deg) begin
                        $error("angle_deg: expected %h actual %h",
                               want.angle_deg, m_tdata[56:32]);
                        fail_count++;
                    end
                    if (m_tuser[1:0] !== want.status) begin
                        $error("status: expected %0d actual %0d",
                               want.status, m_tuser[1:0]);
                        fail_count++;
                    end
                end
            end
        end
        pending = mean_q.size();
    end

endmodule

[bench/tb_complex_mean_to_polar.sv]
// Bench top: clock, reset, config writes, sample stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_complex_mean_to_polar;
    import tb_cmtp_regs_pkg::*;

    localparam int ITEM_TARGET = 750;
    localparam logic [31:0] ONE      = 32'h0001_0000;
    localparam logic [31:0] RAD_TOP  = 32'd90 << 16;   // first radius out of range

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = REG_SAMPLE_COUNT;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [7:0]  m_tuser;

    int  fail_count;
    int  pending;
    int  sent = 0;
    bit  calm = 1'b0;       // both sides run without gaps while set
    bit  hold_go = 1'b0;    // kicks off the long receiver hold-off
    bit  cur_form = FORM_RECT;
    int  hold_cycles = 0;
    bit  i_hold_done = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    complex_mean_to_polar i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    cmtp_checker i_checker (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .fail_count, .pending
    );

    // Result sink: random stalls, one long hold-off so the job queue backs up.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_go && !i_hold_done)
                m_tready <= 1'b0;
            else
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    // ends the hold-off window once hold_cycles reaches its limit
    always @(posedge aclk) begin
        if (hold_go && !i_hold_done) begin
            hold_cycles++;
            if (hold_cycles >= 600) i_hold_done <= 1'b1;
        end
    end

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic [8:0] cnt, input logic form);
        write_reg(REG_SAMPLE_COUNT, cnt);
        write_reg(REG_INPUT_FORM, 9'(form));
        cur_form = form;
    endtask

    // Drains outstanding results, then covers a polar sample still in flight.
    task automatic settle();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_sample(input logic [31:0] a, input logic [31:0] b);
        if (!calm && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    function automatic logic [31:0] rand_rect();
        if ($urandom_range(1)) return $urandom();
        return 32'($signed($urandom_range(2000)) - 1000) <<< 16 | $urandom_range(16'hFFFF);
    endfunction

    task automatic send_random();
        int pick;
        logic [31:0] a, b;
        if (cur_form == FORM_RECT) begin
            send_sample(rand_rect(), rand_rect());
        end else begin
            pick = $urandom_range(99);
            a = $urandom_range(RAD_TOP - 1, 1);
            b = $urandom_range(1) ? $urandom_range(32'h7FFF_FFFF, 1)
                                  : $urandom_range(32'd720 << 16, 1);
            if (pick < 5) a = $urandom();
            else if (pick < 8) a = RAD_TOP + $urandom_range(1000);
            else if (pick < 10) a = 32'd0;
            else if (pick < 15) b = -$urandom_range(32'h7FFF_FFFF, 0);
            send_sample(a, b);
        end
    endtask

    function automatic logic [8:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 9'($urandom_range(8, 1));
        if (r < 85) return 9'($urandom_range(40, 9));
        if (r < 90) return 9'd0;
        if (r < 95) return 9'd256;
        return 9'($urandom_range(511, 257));
    endfunction

    initial begin
        int phase;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // rectangular extremes, the second, third and fourth quadrants, one sample per mean
        set_mode(9'd1, FORM_RECT);
        send_sample(32'h0, 32'h0);                  // zero mean
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 32'h0);          // angle on the negative axis
        settle();

        // polar range errors and wrapped angles
        set_mode(9'd1, FORM_POLAR);
        send_sample(32'h0, ONE);                    // radius zero
        send_sample(32'hFFFF_FFFF, ONE);            // negative radius
        send_sample(RAD_TOP, ONE);                  // radius at the top bound
        send_sample(ONE, 32'h0);                    // angle zero
        send_sample(ONE, 32'h8000_0000);            // negative angle
        send_sample(32'h1, 32'h1);
        send_sample(RAD_TOP - 1, 32'h7FFF_FFFF);
        send_sample(32'd45 << 16, 32'd90 << 16);
        send_sample(32'd45 << 16, 32'd180 << 16);
        send_sample(32'd45 << 16, 32'd270 << 16);
        send_sample(32'd45 << 16, 32'd360 << 16);
        send_sample(32'd45 << 16, (32'd720 << 16) + 1);
        settle();

        // count zero acts as one; an error clears a partial mean
        set_mode(9'd0, FORM_RECT);
        send_sample(ONE, ONE);
        settle();
        set_mode(9'd2, FORM_POLAR);
        send_sample(32'd10 << 16, 32'd30 << 16);
        send_sample(32'd95 << 16, ONE);
        send_sample(32'd10 << 16, 32'd30 << 16);
        send_sample(32'd20 << 16, 32'd200 << 16);
        settle();

        // back-pressure: single-sample means while the sink holds off
        set_mode(9'd1, FORM_RECT);
        hold_go = 1'b1;
        repeat (80) send_random();
        settle();

        phase = 0;
        while (sent < ITEM_TARGET) begin
            calm = (phase == 4);
            set_mode(pick_count(), 1'($urandom_range(1)));
            repeat ($urandom_range(60, 5)) begin
                if (sent < ITEM_TARGET) send_random();
            end
            settle();
            phase++;
        end
        calm = 1'b0;

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
